FILE: hw/rtl/qdec_pkg.sv
package qdec_pkg;

  // Character codes used by the decoder
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_DEL        = 8'h7F;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_EQUALS     = 8'h3D;

  // Offsets that map an ASCII hex digit to its value, picked by bits 6:5
  localparam logic [7:0] HEX_OFS_DIGIT = 8'h30;
  localparam logic [7:0] HEX_OFS_UPPER = 8'h37;
  localparam logic [7:0] HEX_OFS_LOWER = 8'h57;

  // Escape phase: plain byte, first hex digit, second hex digit
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_HI    = 2'd1,
    PH_LO    = 2'd2
  } qdec_phase_t;

  // Decode result handed from the core to the output register
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       status;
    logic       end_flag;
  } qdec_res_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] ofs;
    logic [7:0] d;
    unique case (c[6:5])
      2'd1:    ofs = HEX_OFS_DIGIT;
      2'd2:    ofs = HEX_OFS_UPPER;
      2'd3:    ofs = HEX_OFS_LOWER;
      default: ofs = 8'h00;
    endcase
    d = c - ofs;
    return d[3:0];
  endfunction

endpackage

FILE: hw/rtl/qdec_in_reg.sv
module qdec_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_word_end,
  input  logic       out_free,
  output logic       fire,
  output logic [7:0] byte_q,
  output logic       end_q
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       end_r;
  logic       take;

  // Stage holds one word; it drains whenever the result side has room
  assign fire     = vld_r && out_free;
  assign in_stall = vld_r && !out_free;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
      end_r  <= in_word_end;
    end
  end

  assign byte_q = byte_r;
  assign end_q  = end_r;

endmodule

FILE: hw/rtl/qdec_core.sv
module qdec_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           byte_q,
  input  logic                 end_q,
  output qdec_pkg::qdec_res_t  res,
  output logic                 discard
);

  qdec_pkg::qdec_phase_t phase_r, phase_nxt;
  logic [3:0]            nib_r, nib_nxt;
  logic                  disc_r, disc_nxt;
  logic                  hex;
  logic [3:0]            hval;

  assign hex     = qdec_pkg::is_hex(byte_q);
  assign hval    = qdec_pkg::hex_value(byte_q);
  assign discard = disc_r;

  // Decode one word and work out the next escape state
  always_comb begin
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    disc_nxt  = disc_r;
    res       = '0;
    if (fire) begin
      if (disc_r) begin
        // drop bytes up to the end of the bad word
        if (end_q) begin
          disc_nxt  = 1'b0;
          phase_nxt = qdec_pkg::PH_PLAIN;
        end
      end else begin
        unique case (phase_r)
          qdec_pkg::PH_HI: begin
            if (!hex || end_q) begin
              res.vld = 1'b1;
              res.status = 1'b1;
              res.end_flag = end_q;
              phase_nxt = qdec_pkg::PH_PLAIN;
              disc_nxt = !end_q;
            end else begin
              nib_nxt   = hval;
              phase_nxt = qdec_pkg::PH_LO;
            end
          end
          qdec_pkg::PH_LO: begin
            res.vld      = 1'b1;
            res.end_flag = end_q;
            phase_nxt    = qdec_pkg::PH_PLAIN;
            if (!hex) begin
              res.status = 1'b1;
              disc_nxt   = !end_q;
            end else begin
              res.data = {nib_r, hval};
            end
          end
          default: begin
            // plain byte; unreachable phase code acts the same
            phase_nxt = qdec_pkg::PH_PLAIN;
            if (byte_q == qdec_pkg::CH_UNDERSCORE) begin
              res.vld      = 1'b1;
              res.data     = qdec_pkg::CH_SPACE;
              res.end_flag = end_q;
            end else if (byte_q == qdec_pkg::CH_EQUALS) begin
              if (end_q) begin
                res.vld      = 1'b1;
                res.status   = 1'b1;
                res.end_flag = 1'b1;
              end else begin
                phase_nxt = qdec_pkg::PH_HI;
              end
            end else if (byte_q > qdec_pkg::CH_SPACE && byte_q < qdec_pkg::CH_DEL) begin
              res.vld      = 1'b1;
              res.data     = byte_q;
              res.end_flag = end_q;
            end else begin
              res.vld      = 1'b1;
              res.status   = 1'b1;
              res.end_flag = end_q;
              disc_nxt     = !end_q;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qdec_pkg::PH_PLAIN;
      nib_r   <= 4'h0;
      disc_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

FILE: hw/rtl/qdec_out_reg.sv
module qdec_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  qdec_pkg::qdec_res_t res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_status,
  output logic                out_end_flag
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       status_r;
  logic       end_r;
  logic       load;

  // Room when empty or when the held word leaves this cycle
  assign out_free = !vld_r || !out_stall;
  assign load     = out_free && fire && res.vld;

  always_comb begin
    vld_nxt = vld_r;
    if (out_free) begin
      vld_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= res.data;
      status_r <= res.status;
      end_r    <= res.end_flag;
    end
  end

  assign out_valid    = vld_r;
  assign out_byte     = byte_r;
  assign out_status   = status_r;
  assign out_end_flag = end_r;

endmodule

FILE: hw/rtl/q_encoding_decoder_unit.sv
// Channel  Ports                                         Direction
// in       in_valid, in_stall, in_byte, in_word_end      byte stream in
// out      out_valid, out_stall, out_byte, out_status,   decoded word out
//          out_end_flag
//
// One byte per cycle unless out_stall holds a result; the decode between
// the two registers is combinational and feeds the output register.
// Reset (rst_n low, synchronous) empties both registers and rearms the
// escape and discard state.
// out_stall holds the result; in_stall rises only when the input register
// is full and the result register cannot take its word.
module q_encoding_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_word_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_status,
  output logic       out_end_flag
);

  logic                out_free;
  logic                fire;
  logic [7:0]          byte_q;
  logic                end_q;
  logic                discard;
  qdec_pkg::qdec_res_t res;

  qdec_in_reg u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_word_end (in_word_end),
    .out_free    (out_free),
    .fire        (fire),
    .byte_q      (byte_q),
    .end_q       (end_q)
  );

  qdec_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .byte_q  (byte_q),
    .end_q   (end_q),
    .res     (res),
    .discard (discard)
  );

  qdec_out_reg u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .res          (res),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_status   (out_status),
    .out_end_flag (out_end_flag)
  );

  // Error words carry a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_byte == 8'h00)
    else $error("error word with nonzero byte");

  // Nothing is produced while dropping the rest of a bad word
  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    discard && fire |-> !res.vld)
    else $error("result produced while discarding");

  // Stall to the input only when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

FILE: bench/testbench.sv
module testbench;

  localparam int unsigned RAND_ITEMS  = 1800;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DIR_ROWS    = 25;

  // One decoded result word as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       status;
    logic       end_flag;
  } decoded_t;

  // How a stimulus row is checked
  typedef enum logic [1:0] {
    BY_MODEL  = 2'd0,
    NO_RESULT = 2'd1,
    TYPED     = 2'd2
  } row_check_t;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
    row_check_t chk;
    decoded_t   want;
  } stim_row_t;

  // Directed rows: printable extremes, escapes, every error path, dropping
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{8'h41,                   1'b0, TYPED,     '{8'h41, 1'b0, 1'b0}},
    '{qdec_pkg::CH_UNDERSCORE, 1'b0, TYPED,     '{8'h20, 1'b0, 1'b0}},
    '{8'h21,                   1'b0, TYPED,     '{8'h21, 1'b0, 1'b0}},
    '{8'h7E,                   1'b0, TYPED,     '{8'h7E, 1'b0, 1'b0}},
    '{8'h3F,                   1'b0, TYPED,     '{8'h3F, 1'b0, 1'b0}},
    '{qdec_pkg::CH_EQUALS,     1'b0, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    '{8'h46,                   1'b0, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    '{8'h66,                   1'b0, BY_MODEL,  '{8'h00, 1'b0, 1'b0}},
    '{qdec_pkg::CH_EQUALS,     1'b0, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    '{8'h30,                   1'b0, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    '{8'h30,                   1'b1, BY_MODEL,  '{8'h00, 1'b0, 1'b0}},
    // control byte poisons the encoded word; rest is dropped up to its end
    '{8'h20,                   1'b0, TYPED,     '{8'h00, 1'b1, 1'b0}},
    '{8'h41,                   1'b0, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    '{qdec_pkg::CH_EQUALS,     1'b1, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    // escape cut short by the end mark, at the opener and at the first digit
    '{qdec_pkg::CH_EQUALS,     1'b1, TYPED,     '{8'h00, 1'b1, 1'b1}},
    '{qdec_pkg::CH_EQUALS,     1'b0, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    '{8'h61,                   1'b1, TYPED,     '{8'h00, 1'b1, 1'b1}},
    // bad first digit, then drop
    '{qdec_pkg::CH_EQUALS,     1'b0, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    '{8'h47,                   1'b0, TYPED,     '{8'h00, 1'b1, 1'b0}},
    '{8'hFF,                   1'b1, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    // bad second digit
    '{qdec_pkg::CH_EQUALS,     1'b0, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    '{8'h39,                   1'b0, NO_RESULT, '{8'h00, 1'b0, 1'b0}},
    '{8'h80,                   1'b1, TYPED,     '{8'h00, 1'b1, 1'b1}},
    '{qdec_pkg::CH_DEL,        1'b1, TYPED,     '{8'h00, 1'b1, 1'b1}},
    '{8'h00,                   1'b1, TYPED,     '{8'h00, 1'b1, 1'b1}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_word_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_status;
  logic       out_end_flag;

  // decoder state mirror
  qdec_pkg::qdec_phase_t dec_phase = qdec_pkg::PH_PLAIN;
  logic [3:0]            dec_hi_nibble = 4'h0;
  logic                  dec_dropping = 1'b0;

  decoded_t    decoded_q [$];
  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 37;

  q_encoding_decoder_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_word_end (in_word_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_status  (out_status),
    .out_end_flag(out_end_flag)
  );

  always #6 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic hex_digit_ok(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // letters of either case share their low nibble: 'A' and 'a' end in 1
  function automatic logic [3:0] hex_digit_val(input logic [7:0] c);
    if (c <= 8'h39) return c[3:0];
    return c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] rand_hex();
    int unsigned v;
    v = $urandom_range(15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic stim_row_t mk_row(input logic [7:0] b, input logic e);
    stim_row_t r;
    r = '0;
    r.b = b;
    r.e = e;
    r.chk = BY_MODEL;
    return r;
  endfunction

  // Predict the decoder for one accepted byte; advances the mirror state
  task automatic predict_decode(input logic [7:0] c, input logic last,
                                output logic hit, output decoded_t res);
    logic bad;
    bad = 1'b0;
    hit = 1'b0;
    res = '0;
    if (dec_dropping) begin
      if (last) begin
        dec_dropping = 1'b0;
        dec_phase = qdec_pkg::PH_PLAIN;
      end
    end else begin
      case (dec_phase)
        qdec_pkg::PH_HI: begin
          if (!hex_digit_ok(c) || last) begin
            bad = 1'b1;
          end else begin
            dec_hi_nibble = hex_digit_val(c);
            dec_phase = qdec_pkg::PH_LO;
          end
        end
        qdec_pkg::PH_LO: begin
          if (!hex_digit_ok(c)) begin
            bad = 1'b1;
          end else begin
            hit = 1'b1;
            res.data = {dec_hi_nibble, hex_digit_val(c)};
            dec_phase = qdec_pkg::PH_PLAIN;
          end
        end
        default: begin
          dec_phase = qdec_pkg::PH_PLAIN;
          if (c == qdec_pkg::CH_UNDERSCORE) begin
            hit = 1'b1;
            res.data = qdec_pkg::CH_SPACE;
          end else if (c == qdec_pkg::CH_EQUALS) begin
            if (last) bad = 1'b1;
            else dec_phase = qdec_pkg::PH_HI;
          end else if (c > qdec_pkg::CH_SPACE && c < qdec_pkg::CH_DEL) begin
            hit = 1'b1;
            res.data = c;
          end else begin
            bad = 1'b1;
          end
        end
      endcase
    end
    // any error: one status word, then drop to the end mark
    if (bad) begin
      hit = 1'b1;
      res.data = 8'h00;
      res.status = 1'b1;
      dec_phase = qdec_pkg::PH_PLAIN;
      if (!last) dec_dropping = 1'b1;
    end
    res.end_flag = last;
  endtask

  // Offer one input word, wait for acceptance, record what must come out
  task automatic send_row(input stim_row_t row);
    logic     hit;
    decoded_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= row.b;
    in_word_end <= row.e;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
    predict_decode(row.b, row.e, hit, res);
    case (row.chk)
      BY_MODEL: if (hit) decoded_q = {decoded_q, res};
      TYPED:    decoded_q = {decoded_q, row.want};
      default:  ;
    endcase
  endtask

  // Random encoded word: mostly well formed, some corrupted, some line noise
  task automatic send_random_word();
    logic [7:0]  enc_q [$];
    logic [7:0]  c;
    int unsigned n, sel, pick, k;
    n = $urandom_range(1, 8);
    sel = $urandom_range(99);
    if (sel < 8) begin
      for (k = 0; k < n; k++)
        send_row(mk_row(8'($urandom_range(255)), 1'($urandom_range(1))));
    end else begin
      for (k = 0; k < n; k++) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          do c = 8'($urandom_range(8'h21, 8'h7E));
          while (c == qdec_pkg::CH_UNDERSCORE || c == qdec_pkg::CH_EQUALS);
          enc_q = {enc_q, c};
        end else if (pick < 70) begin
          enc_q = {enc_q, qdec_pkg::CH_UNDERSCORE};
        end else begin
          enc_q = {enc_q, qdec_pkg::CH_EQUALS};
          enc_q = {enc_q, rand_hex()};
          enc_q = {enc_q, rand_hex()};
        end
      end
      // corruption: stray byte, escape cut at the end, or bad digit
      if (sel >= 80) begin
        case ($urandom_range(3))
          0: enc_q[$urandom_range(enc_q.size() - 1)] = 8'($urandom_range(255));
          1: enc_q = {enc_q, qdec_pkg::CH_EQUALS};
          2: begin
            enc_q = {enc_q, qdec_pkg::CH_EQUALS};
            enc_q = {enc_q, rand_hex()};
          end
          default: begin
            enc_q = {enc_q, qdec_pkg::CH_EQUALS};
            if ($urandom_range(1)) enc_q = {enc_q, rand_hex()};
            enc_q = {enc_q, 8'($urandom_range(255))};
            enc_q = {enc_q, rand_hex()};
          end
        endcase
      end
      for (k = 0; k < enc_q.size(); k++)
        send_row(mk_row(enc_q[k], k == enc_q.size() - 1));
    end
  endtask

  // Hold the sender until every expected word has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // Result check and receiver stall
  always @(posedge clk) begin : result_check
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte=%h status=%b end_flag=%b",
               out_byte, out_status, out_end_flag);
        err_cnt++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_byte);
          err_cnt++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %b, got %b", want.status, out_status);
          err_cnt++;
        end
        if (out_end_flag !== want.end_flag) begin
          $error("out_end_flag: expected %b, got %b", want.end_flag, out_end_flag);
          err_cnt++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Stimulus
  initial begin : stimulus
    int unsigned i;
    logic        paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) send_row(DIR_TAB[i]);
    drain_results();

    while (sent_cnt < RAND_ITEMS) begin
      // a stretch with no idling on either side
      idle_pct = (sent_cnt >= 700 && sent_cnt < 1000) ? 0 : 37;
      if (!paused && sent_cnt >= 1300) begin
        drain_results();
        paused = 1'b1;
      end
      send_random_word();
    end

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/qdec_pkg.sv
hw/rtl/qdec_in_reg.sv
hw/rtl/qdec_core.sv
hw/rtl/qdec_out_reg.sv
hw/rtl/q_encoding_decoder_unit.sv
bench/testbench.sv
